// ===== design/ile_pkg.sv =====
`timescale 1ns / 1ps

package ile_pkg;

  localparam int DEPTH       = 256;
  localparam int ENTRY_WIDTH = 32;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int DATA_W = 32;
  localparam int FIDX_W = 8;
  localparam int CNTO_W = 9;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_READ   = 3'd4,
    ACT_FIND   = 3'd5
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_UP,
    S_DN,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              vld;
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [FIDX_W-1:0] found_index;
    logic [CNTO_W-1:0] count;
  } res_t;

  function automatic logic [ENTRY_WIDTH-1:0] to_entry(input logic [VAL_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ENTRY_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_data(input logic [ENTRY_WIDTH-1:0] e);
    logic [63:0] w;
    w = 64'(e);
    return w[DATA_W-1:0];
  endfunction

endpackage

// ===== design/ile_ram.sv =====
`timescale 1ns / 1ps

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ile_ctrl.sv =====
`timescale 1ns / 1ps

module ile_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ile_pkg::ACT_W-1:0]       action_i,
  input  logic [ile_pkg::POS_W-1:0]       position_i,
  input  logic [ile_pkg::VAL_W-1:0]       value_i,
  output logic                            we_o,
  output logic [ile_pkg::ADDR_W-1:0]      waddr_o,
  output logic [ile_pkg::ENTRY_WIDTH-1:0] wdata_o,
  output logic [ile_pkg::ADDR_W-1:0]      raddr_o,
  input  logic [ile_pkg::ENTRY_WIDTH-1:0] rdata_i,
  output ile_pkg::res_t                   res_o,
  input  logic                            res_take_i
);

  import ile_pkg::*;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       paddr_q;
  logic [ENTRY_WIDTH-1:0] key_q, key_d;
  logic                   pend_q, more_q, more_d;
  status_e                st_q, st_d;
  logic [DATA_W-1:0]      data_q, data_d;
  logic [FIDX_W-1:0]      fidx_q, fidx_d;

  logic             accept, full, empty, issue, hit, walk;
  logic             pos_gt, pos_ge, pos_eq, pos_last;
  logic [CNT_W-1:0] cnt_m1, raddr_w;
  act_e             act;

  assign act      = act_e'(action_i);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign pos_gt   = CMP_W'(position_i) >  CMP_W'(cnt_q);
  assign pos_ge   = CMP_W'(position_i) >= CMP_W'(cnt_q);
  assign pos_eq   = CMP_W'(position_i) == CMP_W'(cnt_q);
  assign pos_last = CMP_W'(position_i) == CMP_W'(cnt_m1);
  assign walk     = (state_q == S_UP) || (state_q == S_DN) || (state_q == S_SCAN);
  assign issue    = walk && more_q;
  assign hit      = (state_q == S_SCAN) && pend_q && (rdata_i == key_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_POP:    state_d = empty ? S_FINISH : S_WAIT;
            ACT_INSERT: state_d = (pos_gt || full || pos_eq) ? S_FINISH : S_UP;
            ACT_REMOVE: state_d = (pos_ge || pos_last) ? S_FINISH : S_DN;
            ACT_READ:   state_d = pos_ge ? S_FINISH : S_WAIT;
            ACT_FIND:   state_d = empty ? S_FINISH : S_SCAN;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_WAIT: state_d = S_FINISH;
      S_UP, S_DN: begin
        if (!more_q && !pend_q) begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        if (hit || (!more_q && !pend_q)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    key_d   = key_q;
    more_d  = more_q;
    st_d    = st_q;
    data_d  = data_q;
    fidx_d  = fidx_q;
    we_o    = 1'b0;
    waddr_o = ptr_q[ADDR_W-1:0];
    wdata_o = rdata_i;
    raddr_w = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d   = ST_OK;
          data_d = '0;
          fidx_d = '0;
          key_d  = to_entry(value_i);
          pos_d  = CNT_W'(position_i);
          more_d = 1'b0;
          case (act)
            ACT_PUSH: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                we_o    = 1'b1;
                waddr_o = cnt_q[ADDR_W-1:0];
                wdata_o = to_entry(value_i);
                cnt_d   = cnt_q + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                raddr_w = cnt_m1;
                cnt_d   = cnt_m1;
              end
            end
            ACT_INSERT: begin
              if (pos_gt) begin
                st_d = ST_RANGE;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
                if (pos_eq) begin
                  we_o    = 1'b1;
                  waddr_o = cnt_q[ADDR_W-1:0];
                  wdata_o = to_entry(value_i);
                end else begin
                  ptr_d  = cnt_m1;
                  more_d = 1'b1;
                end
              end
            end
            ACT_REMOVE: begin
              if (pos_ge) begin
                st_d = ST_RANGE;
              end else begin
                cnt_d = cnt_m1;
                if (!pos_last) begin
                  ptr_d  = CNT_W'(position_i) + CNT_W'(1);
                  more_d = 1'b1;
                end
              end
            end
            ACT_READ: begin
              if (pos_ge) begin
                st_d = ST_RANGE;
              end else begin
                raddr_w = CNT_W'(position_i);
              end
            end
            ACT_FIND: begin
              st_d = ST_NOTFOUND;
              if (!empty) begin
                ptr_d  = '0;
                more_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WAIT: data_d = to_data(rdata_i);
      S_UP: begin
        if (issue) begin
          ptr_d  = ptr_q - CNT_W'(1);
          more_d = (ptr_q != pos_q);
        end
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = ADDR_W'(paddr_q + CNT_W'(1));
        end else if (!more_q) begin
          we_o    = 1'b1;
          waddr_o = pos_q[ADDR_W-1:0];
          wdata_o = key_q;
        end
      end
      S_DN: begin
        if (issue) begin
          ptr_d  = ptr_q + CNT_W'(1);
          more_d = (ptr_q != cnt_q);
        end
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = ADDR_W'(paddr_q - CNT_W'(1));
        end
      end
      S_SCAN: begin
        if (issue) begin
          ptr_d  = ptr_q + CNT_W'(1);
          more_d = (ptr_q != cnt_m1);
        end
        if (hit) begin
          st_d   = ST_OK;
          fidx_d = FIDX_W'(paddr_q);
          more_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign raddr_o    = raddr_w[ADDR_W-1:0];
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    res_o.vld         = (state_q == S_FINISH);
    res_o.status      = st_q;
    res_o.data        = data_q;
    res_o.found_index = fidx_q;
    res_o.count       = CNTO_W'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      more_q  <= more_d;
      pend_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    pos_q   <= pos_d;
    key_q   <= key_d;
    paddr_q <= ptr_q;
    st_q    <= st_d;
    data_q  <= data_d;
    fidx_q  <= fidx_d;
  end

endmodule

// ===== design/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list engine: up to DEPTH entries packed from position 0.
// Input channel (in_valid_i/in_ready_o): action_i, position_i, value_i.
//   push, pop, insert, remove, read, find; codes 6 and 7 do nothing.
// Output channel (out_valid_o/out_ready_i): status_o, data_o,
//   found_index_o, count_o; exactly one result item per input item.
// One item is worked at a time; in_ready_o is high while the sequencer
// is idle. Entries live in one RAM with one write and one registered
// read port, so the walk over entries sets the cost:
//   push, errors, no-op codes: no RAM read, straight to the result
//   read, pop:                 wait for one registered RAM read
//   insert at p < count:       moves entries p..count-1 up one place, writes at p
//   remove at p < count - 1:   moves entries p+1..count-1 down one place
//   insert at count, remove of the last entry: no walk
//   find:                      reads from entry 0 up to the first match or the end
// A result waits in an output register; while the receiver stalls the
// next item is still accepted and worked, and is held until that register
// frees up. Reset empties the list (count zero) and returns to idle;
// the RAM is not cleared since only entries below count are ever read.
module indexed_list_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ile_pkg::ACT_W-1:0]    action_i,
  input  logic [ile_pkg::POS_W-1:0]    position_i,
  input  logic [ile_pkg::VAL_W-1:0]    value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ile_pkg::ST_W-1:0]     status_o,
  output logic [ile_pkg::DATA_W-1:0]   data_o,
  output logic [ile_pkg::FIDX_W-1:0]   found_index_o,
  output logic [ile_pkg::CNTO_W-1:0]   count_o
);

  import ile_pkg::*;

  logic                   we;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [ENTRY_WIDTH-1:0] wdata, rdata;
  res_t                   res;
  logic                   take;
  logic                   out_vld_q;
  res_t                   out_res_q;

  ile_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ile_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .res_o      (res),
    .res_take_i (take)
  );

  assign take = res.vld && (!out_vld_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_res_q.status;
  assign data_o        = out_res_q.data;
  assign found_index_o = out_res_q.found_index;
  assign count_o       = out_res_q.count;

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res.vld)
    else $error("result pending while sequencer idle");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (count_o == CNTO_W'(DEPTH)))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> (count_o == '0))
    else $error("empty status with entries held");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> ((data_o == '0) && (found_index_o == '0)))
    else $error("error result carries data");

endmodule

// ===== sim/indexed_list_checker.sv =====
`timescale 1ns / 1ps

module indexed_list_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic [ile_pkg::ACT_W-1:0]  action_i,
  input  logic [ile_pkg::POS_W-1:0]  position_i,
  input  logic [ile_pkg::VAL_W-1:0]  value_i,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic [ile_pkg::ST_W-1:0]   status_o,
  input  logic [ile_pkg::DATA_W-1:0] data_o,
  input  logic [ile_pkg::FIDX_W-1:0] found_index_o,
  input  logic [ile_pkg::CNTO_W-1:0] count_o,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         level_o,
  output int                         checked_o
);

  import ile_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [FIDX_W-1:0] found_index;
    logic [CNTO_W-1:0] count;
  } reply_t;

  logic [ENTRY_WIDTH-1:0] list_mem [DEPTH];
  int                     list_len = 0;
  reply_t                 owed_replies [$];
  int                     fails = 0;
  int                     checked = 0;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic apply_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, output reply_t r);
    logic [ENTRY_WIDTH-1:0] key;
    int                     i;
    bit                     hit;
    key = val[ENTRY_WIDTH-1:0];
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (act)
      ACT_PUSH: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = key;
          list_len++;
        end
      end
      ACT_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_len--;
          r.data = DATA_W'(list_mem[list_len]);
        end
      end
      ACT_INSERT: begin
        if (int'(pos) > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = key;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        if (int'(pos) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_READ: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else r.data = DATA_W'(list_mem[pos]);
      end
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_mem[i] == key) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = FIDX_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.count = CNTO_W'(list_len);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    reply_t next_reply;
    if (!rst_ni) begin
      list_len = 0;
      owed_replies.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_replies.size() == 0) begin
          $error("result item with no request outstanding");
          fails++;
        end else begin
          want = owed_replies.pop_front();
          compare_field("status", 32'(want.status), 32'(status_o));
          compare_field("data", 32'(want.data), 32'(data_o));
          compare_field("found_index", 32'(want.found_index), 32'(found_index_o));
          compare_field("count", 32'(want.count), 32'(count_o));
          checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_request(action_i, position_i, value_i, next_reply);
        owed_replies.push_back(next_reply);
      end
    end
    fail_count_o <= fails;
    pending_o    <= owed_replies.size();
    level_o      <= list_len;
    checked_o    <= checked;
  end

endmodule

// ===== sim/indexed_list_engine_test.sv =====
`timescale 1ns / 1ps

module indexed_list_engine_test;
  import ile_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1600;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [1:0] {
    PH_GROW,
    PH_FULL_HOLD,
    PH_SHRINK,
    PH_EMPTY_HOLD
  } phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ACT_W-1:0]  action_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic [VAL_W-1:0]  value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ST_W-1:0]   status_o;
  logic [DATA_W-1:0] data_o;
  logic [FIDX_W-1:0] found_index_o;
  logic [CNTO_W-1:0] count_o;

  int     fail_count;
  int     pending;
  int     level;
  int     checked;
  int     stall_cycles = 0;
  int     sent_by_action [8];
  int     fills = 0;
  int     drains = 0;
  bit     no_idle = 1'b0;
  phase_e phase = PH_GROW;
  int     hold_left = 0;

  always #10 clk_i = ~clk_i;

  indexed_list_engine i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .position_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .data_o,
    .found_index_o,
    .count_o
  );

  indexed_list_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .position_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .data_o,
    .found_index_o,
    .count_o,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .level_o      (level),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_by_action[act]++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) != 0) return VAL_W'($urandom_range(0, 31));
    return $urandom();
  endfunction

  // insert, remove, read: mostly in-range positions, some past the end; others: any
  function automatic logic [POS_W-1:0] pick_position(input logic [ACT_W-1:0] act,
                                                     input int len);
    int top_ok;
    top_ok = (act == ACT_INSERT) ? len : len - 1;
    if (top_ok > 255) top_ok = 255;
    if (act != ACT_INSERT && act != ACT_REMOVE && act != ACT_READ) begin
      return POS_W'($urandom_range(0, 255));
    end
    if (top_ok >= 0 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, top_ok));
    if (top_ok >= 255) return POS_W'(255);
    return POS_W'($urandom_range(top_ok + 1, 255));
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input phase_e ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return ($urandom_range(0, 1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
    case (ph)
      PH_GROW: begin
        if (roll < 48) return ACT_PUSH;
        if (roll < 72) return ACT_INSERT;
        if (roll < 81) return ACT_READ;
        if (roll < 90) return ACT_FIND;
        if (roll < 95) return ACT_POP;
        return ACT_REMOVE;
      end
      PH_SHRINK: begin
        if (roll < 38) return ACT_POP;
        if (roll < 68) return ACT_REMOVE;
        if (roll < 77) return ACT_READ;
        if (roll < 86) return ACT_FIND;
        if (roll < 93) return ACT_PUSH;
        return ACT_INSERT;
      end
      default: return act_e'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin : stimulus
    logic [ACT_W-1:0] act;
    int               n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_POP, 8'd0, 32'h0);
    send_item(ACT_READ, 8'd0, 32'h0);
    send_item(ACT_REMOVE, 8'd0, 32'h0);
    send_item(ACT_FIND, 8'd0, 32'h0);
    send_item(ACT_INSERT, 8'd1, 32'h5);
    send_item(ACT_INSERT, 8'd255, 32'h6);
    send_item(ACT_PUSH, 8'd255, 32'hFFFF_FFFF);
    send_item(ACT_PUSH, 8'd0, 32'h0);
    send_item(ACT_INSERT, 8'd0, 32'hA5A5_A5A5);
    send_item(ACT_INSERT, 8'd3, 32'h1);
    send_item(ACT_INSERT, 8'd2, 32'h7);
    send_item(ACT_READ, 8'd0, 32'h0);
    send_item(ACT_READ, 8'd4, 32'hFFFF_FFFF);
    send_item(ACT_READ, 8'd5, 32'h0);
    send_item(ACT_FIND, 8'd0, 32'h0);
    send_item(ACT_FIND, 8'd255, 32'hFFFF_FFFF);
    send_item(ACT_FIND, 8'd0, 32'h1234_5678);
    send_item(ACT_PUSH, 8'd0, 32'h7);
    send_item(ACT_FIND, 8'd0, 32'h7);
    send_item(ACT_REMOVE, 8'd0, 32'h0);
    send_item(ACT_REMOVE, 8'd4, 32'h0);
    send_item(ACT_REMOVE, 8'd255, 32'h0);
    send_item(ACT_UNDEF_LO, 8'd0, 32'h0);
    send_item(ACT_UNDEF_HI, 8'd255, 32'hFFFF_FFFF);
    send_item(ACT_POP, 8'd0, 32'h0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 600 && n < 800);
      case (phase)
        PH_GROW: begin
          if (level >= DEPTH) begin
            phase = PH_FULL_HOLD;
            hold_left = 12;
            fills++;
          end
        end
        PH_FULL_HOLD: begin
          if (--hold_left <= 0) phase = PH_SHRINK;
        end
        PH_SHRINK: begin
          if (level == 0) begin
            phase = PH_EMPTY_HOLD;
            hold_left = 8;
            drains++;
          end
        end
        default: begin
          if (--hold_left <= 0) phase = PH_GROW;
        end
      endcase
      act = pick_action(phase);
      send_item(act, pick_position(act, level), pick_value());
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    // let the checker record the last accepted item before polling
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered push %0d, pop %0d, insert %0d, remove %0d, read %0d, find %0d, undefined %0d",
             sent_by_action[ACT_PUSH], sent_by_action[ACT_POP], sent_by_action[ACT_INSERT],
             sent_by_action[ACT_REMOVE], sent_by_action[ACT_READ], sent_by_action[ACT_FIND],
             sent_by_action[ACT_UNDEF_LO] + sent_by_action[ACT_UNDEF_HI]);
    $display("%0d results checked; list filled to depth %0d times, drained to empty %0d times",
             checked, fills, drains);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
